### src/bot_pkg.sv
// Shared types and constants for the buffer occupancy tracker.
package bot_pkg;

   // Width of every configuration register write
   localparam int CFG_WIDTH = 40;
   localparam int CSR_INDEX_WIDTH = 3;

   // Default widths of the occupancy, traffic and request byte fields
   localparam int OCC_WIDTH_DEF = 40;
   localparam int TRAFFIC_WIDTH_DEF = 48;
   localparam int BYTES_WIDTH_DEF = 32;

   localparam logic [CFG_WIDTH-1:0] CAPACITY_RESET = CFG_WIDTH'(33554432);

   typedef enum logic [2:0] {
      FN_ADD          = 3'd0,
      FN_FIT          = 3'd1,
      FN_REMOVE       = 3'd2,
      FN_EVICT        = 3'd3,
      FN_PLAIN_ADD    = 3'd4,
      FN_PLAIN_REMOVE = 3'd5,
      FN_PLAIN_FIT    = 3'd6
   } func_type;

   typedef enum logic [1:0] {
      RG_A       = 2'd0,
      RG_B       = 2'd1,
      RG_O       = 2'd2,
      RG_UNKNOWN = 2'd3
   } region_type;

   typedef enum logic [1:0] {
      ST_OK     = 2'd0,
      ST_REGION = 2'd1,
      ST_UNDER  = 2'd2,
      ST_SAT    = 2'd3
   } status_type;

   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      CSR_TOTAL_CAPACITY = 3'd0,
      CSR_LIMIT_A        = 3'd1,
      CSR_LIMIT_B        = 3'd2,
      CSR_LIMIT_O        = 3'd3,
      CSR_SPARSE_KERNEL  = 3'd4,
      CSR_DYNAMIC_TILING = 3'd5
   } csr_index_type;

   typedef struct packed {
      logic [CFG_WIDTH-1:0] total_capacity;
      logic [CFG_WIDTH-1:0] limit_a;
      logic [CFG_WIDTH-1:0] limit_b;
      logic [CFG_WIDTH-1:0] limit_o;
      logic                 sparse_kernel;
      logic                 dynamic_tiling;
   } cfg_type;

endpackage

### src/buffer_occupancy_tracker.sv
// Top level of the buffer occupancy tracker: stream ports, stage registers, handshake.
//
// Tracks byte occupancy of a buffer shared by regions A, B and output, the
// total and its peak, and four wrapping traffic totals.
// Channels: req_ carries one request per item (operation, region, bytes);
// rsp_ returns exactly one result per request, in order, showing the state
// after that request. csr_ writes configuration registers by index; it is
// always ready and should only be written while no request is in flight.
// A request is taken into the input register, and its result is then loaded
// into the result register once the result slot frees. Throughput: one item
// per cycle while rsp_tready stays high; the occupancy update is a
// read-modify-write of the state registers, which is what sets that rate.
// Stall: when rsp_tready is low the result holds; one more request can still
// be taken into the input register, after which req_tready drops.
// Reset (synchronous, active high) clears occupancy, peak, traffic totals
// and the valid flags of both stage registers, and loads the configuration
// defaults.
module buffer_occupancy_tracker #(
   parameter int OCC_WIDTH = bot_pkg::OCC_WIDTH_DEF,
   parameter int TRAFFIC_WIDTH = bot_pkg::TRAFFIC_WIDTH_DEF,
   parameter int BYTES_WIDTH = bot_pkg::BYTES_WIDTH_DEF
) (
   input  logic                                            clock,
   input  logic                                            reset,
   // func, region, is_write, byte_count, count_traffic
   input  logic                                            req_tvalid,
   output logic                                            req_tready,
   input  logic [((BYTES_WIDTH + 14) / 8) * 8 - 1:0]       req_tdata,
   // status, fits, used_total, peak_total, a_occupancy, b_occupancy,
   // o_occupancy, a_read_total, b_read_total, o_read_total, o_write_total
   output logic                                            rsp_tvalid,
   input  logic                                            rsp_tready,
   output logic [((5 * OCC_WIDTH + 4 * TRAFFIC_WIDTH + 10) / 8) * 8 - 1:0] rsp_tdata,
   input  logic                                            csr_valid,
   output logic                                            csr_ready,
   input  logic [bot_pkg::CSR_INDEX_WIDTH-1:0]             csr_index,
   input  logic [bot_pkg::CFG_WIDTH-1:0]                   csr_data
);
   import bot_pkg::*;

   localparam int RSP_BITS = 3 + 5 * OCC_WIDTH + 4 * TRAFFIC_WIDTH;
   localparam int RSP_W = ((RSP_BITS + 7) / 8) * 8;

   cfg_type                  cfg;

   logic                     in_valid_ff, in_valid_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic [2:0]               func_ff;
   logic [1:0]               region_ff;
   logic                     is_write_ff;
   logic [BYTES_WIDTH-1:0]   byte_count_ff;
   logic                     count_traffic_ff;
   logic [RSP_W-1:0]         rsp_data_ff;

   logic                     advance, req_take, step;
   logic [1:0]               status;
   logic                     fits;
   logic [OCC_WIDTH-1:0]     used_total, peak_total, a_occupancy, b_occupancy, o_occupancy;
   logic [TRAFFIC_WIDTH-1:0] a_read_total, b_read_total, o_read_total, o_write_total;

   bot_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   bot_core #(
      .OCC_WIDTH     (OCC_WIDTH),
      .TRAFFIC_WIDTH (TRAFFIC_WIDTH),
      .BYTES_WIDTH   (BYTES_WIDTH)
   ) u_core (
      .clock         (clock),
      .reset         (reset),
      .step          (step),
      .cfg           (cfg),
      .func          (func_ff),
      .region        (region_ff),
      .is_write      (is_write_ff),
      .byte_count    (byte_count_ff),
      .count_traffic (count_traffic_ff),
      .status        (status),
      .fits          (fits),
      .used_total    (used_total),
      .peak_total    (peak_total),
      .a_occupancy   (a_occupancy),
      .b_occupancy   (b_occupancy),
      .o_occupancy   (o_occupancy),
      .a_read_total  (a_read_total),
      .b_read_total  (b_read_total),
      .o_read_total  (o_read_total),
      .o_write_total (o_write_total)
   );

   // Handshake: the item in the input register moves on when the result slot frees
   assign advance = !rsp_valid_ff || rsp_tready;
   assign step = in_valid_ff && advance;
   assign req_tready = !in_valid_ff || advance;
   assign req_take = req_tvalid && req_tready;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_take) begin
         in_valid_in = 1'b1;
      end else if (step) begin
         in_valid_in = 1'b0;
      end
      rsp_valid_in = advance ? in_valid_ff : rsp_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Input register, unpacked from the request item
   always_ff @(posedge clock) begin
      if (req_take) begin
         func_ff <= req_tdata[2:0];
         region_ff <= req_tdata[4:3];
         is_write_ff <= req_tdata[5];
         byte_count_ff <= req_tdata[6 +: BYTES_WIDTH];
         count_traffic_ff <= req_tdata[6 + BYTES_WIDTH];
      end
   end

   // Result register, packed from the lowest field up
   always_ff @(posedge clock) begin
      if (step) begin
         rsp_data_ff <= RSP_W'({o_write_total, o_read_total, b_read_total, a_read_total,
                                o_occupancy, b_occupancy, a_occupancy, peak_total,
                                used_total, fits, status});
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata = rsp_data_ff;

endmodule

### src/bot_csr.sv
// Configuration register file of the buffer occupancy tracker.
module bot_csr (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [bot_pkg::CSR_INDEX_WIDTH-1:0]  csr_index,
   input  logic [bot_pkg::CFG_WIDTH-1:0]        csr_data,
   output bot_pkg::cfg_type                     cfg
);
   import bot_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   // Writes are always taken
   assign csr_ready = 1'b1;
   assign cfg = cfg_ff;

   // Register decode; indexes past the list are dropped
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index_type'(csr_index))
            CSR_TOTAL_CAPACITY: cfg_in.total_capacity = csr_data;
            CSR_LIMIT_A:        cfg_in.limit_a = csr_data;
            CSR_LIMIT_B:        cfg_in.limit_b = csr_data;
            CSR_LIMIT_O:        cfg_in.limit_o = csr_data;
            CSR_SPARSE_KERNEL:  cfg_in.sparse_kernel = csr_data[0];
            CSR_DYNAMIC_TILING: cfg_in.dynamic_tiling = csr_data[0];
            default:            cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.total_capacity <= CAPACITY_RESET;
         cfg_ff.limit_a <= CAPACITY_RESET;
         cfg_ff.limit_b <= CAPACITY_RESET;
         cfg_ff.limit_o <= CAPACITY_RESET;
         cfg_ff.sparse_kernel <= 1'b0;
         cfg_ff.dynamic_tiling <= 1'b0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

### src/bot_core.sv
// Occupancy and traffic state with the per-item update logic.
module bot_core #(
   parameter int OCC_WIDTH = bot_pkg::OCC_WIDTH_DEF,
   parameter int TRAFFIC_WIDTH = bot_pkg::TRAFFIC_WIDTH_DEF,
   parameter int BYTES_WIDTH = bot_pkg::BYTES_WIDTH_DEF
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     step,
   input  bot_pkg::cfg_type         cfg,
   input  logic [2:0]               func,
   input  logic [1:0]               region,
   input  logic                     is_write,
   input  logic [BYTES_WIDTH-1:0]   byte_count,
   input  logic                     count_traffic,
   output logic [1:0]               status,
   output logic                     fits,
   output logic [OCC_WIDTH-1:0]     used_total,
   output logic [OCC_WIDTH-1:0]     peak_total,
   output logic [OCC_WIDTH-1:0]     a_occupancy,
   output logic [OCC_WIDTH-1:0]     b_occupancy,
   output logic [OCC_WIDTH-1:0]     o_occupancy,
   output logic [TRAFFIC_WIDTH-1:0] a_read_total,
   output logic [TRAFFIC_WIDTH-1:0] b_read_total,
   output logic [TRAFFIC_WIDTH-1:0] o_read_total,
   output logic [TRAFFIC_WIDTH-1:0] o_write_total
);
   import bot_pkg::*;

   // Working width: room for any sum of two occupancy or byte values
   localparam int WIDE0 = (OCC_WIDTH > BYTES_WIDTH) ? OCC_WIDTH : BYTES_WIDTH;
   localparam int WIDE1 = (WIDE0 > CFG_WIDTH) ? WIDE0 : CFG_WIDTH;
   localparam int SW = WIDE1 + 2;
   localparam logic [SW-1:0] OCC_TOP = {{(SW - OCC_WIDTH){1'b0}}, {OCC_WIDTH{1'b1}}};

   logic [OCC_WIDTH-1:0]     a_ff, b_ff, o_ff, tot_ff, peak_ff;
   logic [OCC_WIDTH-1:0]     a_in, b_in, o_in, tot_in, peak_in;
   logic [TRAFFIC_WIDTH-1:0] ard_ff, brd_ff, ord_ff, owr_ff;
   logic [TRAFFIC_WIDTH-1:0] ard_in, brd_in, ord_in, owr_in;

   logic [OCC_WIDTH-1:0]     held;
   logic [SW-1:0]            bytes_w, held_w, tot_w, limit_w, cap_w;
   logic [SW-1:0]            reg_sum, tot_sum, evict_sum;
   logic                     reg_over, tot_over, evict_over;
   logic                     limit_on, tot_fit, reg_fit, under, plain_under;
   logic [OCC_WIDTH-1:0]     reg_clamp, tot_clamp, evict_clamp, held_sub, tot_sub;
   logic [OCC_WIDTH-1:0]     a_keep, b_keep, o_keep, held_new;
   logic [TRAFFIC_WIDTH-1:0] bytes_t;
   status_type               status_v;
   logic                     fits_v;
   logic                     bad_region;

   // Region selection and the shared adders and compares
   always_comb begin
      case (region_type'(region))
         RG_A: begin
            held = a_ff;
            limit_w = SW'(cfg.limit_a);
            limit_on = cfg.sparse_kernel & cfg.dynamic_tiling;
         end
         RG_B: begin
            held = b_ff;
            limit_w = SW'(cfg.limit_b);
            limit_on = cfg.dynamic_tiling;
         end
         RG_O: begin
            held = o_ff;
            limit_w = SW'(cfg.limit_o);
            limit_on = cfg.sparse_kernel & cfg.dynamic_tiling;
         end
         default: begin
            held = o_ff;
            limit_w = SW'(cfg.limit_o);
            limit_on = 1'b0;
         end
      endcase
   end

   assign bad_region = (region == RG_UNKNOWN);
   assign bytes_w = SW'(byte_count);
   assign bytes_t = TRAFFIC_WIDTH'(byte_count);
   assign held_w = SW'(held);
   assign tot_w = SW'(tot_ff);
   assign cap_w = SW'(cfg.total_capacity);

   assign reg_sum = held_w + bytes_w;
   assign tot_sum = tot_w + bytes_w;
   assign reg_over = reg_sum > OCC_TOP;
   assign tot_over = tot_sum > OCC_TOP;
   assign reg_clamp = reg_over ? {OCC_WIDTH{1'b1}} : reg_sum[OCC_WIDTH-1:0];
   assign tot_clamp = tot_over ? {OCC_WIDTH{1'b1}} : tot_sum[OCC_WIDTH-1:0];

   assign tot_fit = tot_sum <= cap_w;
   assign reg_fit = reg_sum <= limit_w;

   assign under = (bytes_w > tot_w) || (bytes_w > held_w);
   assign plain_under = bytes_w > tot_w;
   assign held_sub = held - bytes_w[OCC_WIDTH-1:0];
   assign tot_sub = tot_ff - bytes_w[OCC_WIDTH-1:0];

   // Evict: total rebuilt from the regions that remain
   assign a_keep = (region == RG_A) ? '0 : a_ff;
   assign b_keep = (region == RG_B) ? '0 : b_ff;
   assign o_keep = (region == RG_O) ? '0 : o_ff;
   assign evict_sum = SW'(a_keep) + SW'(b_keep) + SW'(o_keep);
   assign evict_over = evict_sum > OCC_TOP;
   assign evict_clamp = evict_over ? {OCC_WIDTH{1'b1}} : evict_sum[OCC_WIDTH-1:0];

   // Next state and result for the item
   always_comb begin
      a_in = a_ff;
      b_in = b_ff;
      o_in = o_ff;
      tot_in = tot_ff;
      peak_in = peak_ff;
      ard_in = ard_ff;
      brd_in = brd_ff;
      ord_in = ord_ff;
      owr_in = owr_ff;
      status_v = ST_OK;
      fits_v = 1'b0;
      held_new = held;
      case (func_type'(func))
         FN_ADD: begin
            if (bad_region) begin
               status_v = ST_REGION;
            end else begin
               held_new = reg_clamp;
               tot_in = tot_clamp;
               if (tot_clamp > peak_ff) begin
                  peak_in = tot_clamp;
               end
               if (reg_over || tot_over) begin
                  status_v = ST_SAT;
               end
               if (count_traffic) begin
                  case (region_type'(region))
                     RG_A:    ard_in = ard_ff + bytes_t;
                     RG_B:    brd_in = brd_ff + bytes_t;
                     default: begin
                        if (is_write) begin
                           owr_in = owr_ff + bytes_t;
                        end else begin
                           ord_in = ord_ff + bytes_t;
                        end
                     end
                  endcase
               end
            end
         end
         FN_FIT: begin
            if (bad_region) begin
               status_v = ST_REGION;
            end else begin
               fits_v = tot_fit && (!limit_on || reg_fit);
            end
         end
         FN_REMOVE: begin
            if (bad_region) begin
               status_v = ST_REGION;
            end else if (under) begin
               status_v = ST_UNDER;
            end else begin
               held_new = held_sub;
               tot_in = tot_sub;
               if (region == RG_O && count_traffic) begin
                  owr_in = owr_ff + bytes_t;
               end
            end
         end
         FN_EVICT: begin
            if (bad_region) begin
               status_v = ST_REGION;
            end else begin
               if (region == RG_O && count_traffic) begin
                  owr_in = owr_ff + TRAFFIC_WIDTH'(o_ff);
               end
               held_new = '0;
               tot_in = evict_clamp;
               if (evict_over) begin
                  status_v = ST_SAT;
               end
            end
         end
         FN_PLAIN_ADD: begin
            tot_in = tot_clamp;
            if (tot_clamp > peak_ff) begin
               peak_in = tot_clamp;
            end
            if (tot_over) begin
               status_v = ST_SAT;
            end
         end
         FN_PLAIN_REMOVE: begin
            if (plain_under) begin
               status_v = ST_UNDER;
            end else begin
               tot_in = tot_sub;
            end
         end
         FN_PLAIN_FIT: begin
            fits_v = tot_fit;
         end
         default: begin
            status_v = ST_OK;
         end
      endcase

      // Region write-back for the region-based operations
      if ((func == FN_ADD || func == FN_REMOVE || func == FN_EVICT) && !bad_region) begin
         case (region_type'(region))
            RG_A:    a_in = held_new;
            RG_B:    b_in = held_new;
            default: o_in = held_new;
         endcase
      end
   end

   // State registers, updated once per item
   always_ff @(posedge clock) begin
      if (reset) begin
         a_ff <= '0;
         b_ff <= '0;
         o_ff <= '0;
         tot_ff <= '0;
         peak_ff <= '0;
         ard_ff <= '0;
         brd_ff <= '0;
         ord_ff <= '0;
         owr_ff <= '0;
      end else if (step) begin
         a_ff <= a_in;
         b_ff <= b_in;
         o_ff <= o_in;
         tot_ff <= tot_in;
         peak_ff <= peak_in;
         ard_ff <= ard_in;
         brd_ff <= brd_in;
         ord_ff <= ord_in;
         owr_ff <= owr_in;
      end
   end

   // Result shows the state after the item
   assign status = status_v;
   assign fits = fits_v;
   assign used_total = tot_in;
   assign peak_total = peak_in;
   assign a_occupancy = a_in;
   assign b_occupancy = b_in;
   assign o_occupancy = o_in;
   assign a_read_total = ard_in;
   assign b_read_total = brd_in;
   assign o_read_total = ord_in;
   assign o_write_total = owr_in;

endmodule

### src/bot_checker.sv
// Port-level assertions for the buffer occupancy tracker, bound to the top level.
module bot_checker #(
   parameter int OCC_WIDTH = bot_pkg::OCC_WIDTH_DEF,
   parameter int TRAFFIC_WIDTH = bot_pkg::TRAFFIC_WIDTH_DEF
) (
   input logic                                                    clock,
   input logic                                                    reset,
   input logic                                                    req_tvalid,
   input logic                                                    req_tready,
   input logic                                                    rsp_tvalid,
   input logic                                                    rsp_tready,
   input logic [((5 * OCC_WIDTH + 4 * TRAFFIC_WIDTH + 10) / 8) * 8 - 1:0] rsp_tdata
);
   import bot_pkg::*;

   localparam int PEAK_LO = 3 + OCC_WIDTH;

   logic [1:0]           rsp_status;
   logic                 rsp_fits;
   logic [OCC_WIDTH-1:0] rsp_peak;

   assign rsp_status = rsp_tdata[1:0];
   assign rsp_fits = rsp_tdata[2];
   assign rsp_peak = rsp_tdata[PEAK_LO +: OCC_WIDTH];

   // No result is offered right after reset
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result valid right after reset");

   // A stalled result holds its item
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled result changed");

   // A positive fit answer never comes with an error status
   a_fit_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_fits |-> rsp_status == ST_OK)
      else $error("fit answer with error status");

   // Peak watermark never falls between back-to-back results
   a_peak_mono: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tready |=> !rsp_tvalid || rsp_peak >= $past(rsp_peak))
      else $error("peak watermark decreased");

   // A request is held off only while a result is waiting
   a_req_flow: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && !req_tready |-> rsp_tvalid)
      else $error("request stalled with empty result slot");

endmodule

bind buffer_occupancy_tracker bot_checker #(
   .OCC_WIDTH     (OCC_WIDTH),
   .TRAFFIC_WIDTH (TRAFFIC_WIDTH)
) u_bot_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
